// ===== hdl/chte_pkg.sv =====
// ---------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// request kinds, status codes, state encodings and the fnv-1a step
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chte_pkg;

  localparam int DEF_CAPACITY   = 32;
  localparam int DEF_BUCKETS    = 97;
  localparam int DEF_KEY_BYTES  = 8;
  localparam int DEF_VALUE_BITS = 32;

  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;
  localparam int ECOUNT_W = 6;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  // prime is 2^40 + 2^8 + 0xb3
  localparam logic [7:0]  FNV_PRIME_LOW = 8'hb3;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIND   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_RSVD   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_WALK,
    ST_MISS,
    ST_INS_LINK,
    ST_RM_LAST,
    ST_RM_MOVE,
    ST_RM_HEAD,
    ST_RM_WALK,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FNV,
    PH_MOD
  } hash_phase_t;

  // one fnv-1a round, multiply by the prime done as shifts plus an 8-bit product
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    begin
      x = h ^ {56'd0, b};
      fnv_step = (x << 40) + (x << 8) + (x * {56'd0, FNV_PRIME_LOW});
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/chained_hash_table_engine.sv =====
// ---------------------------------------------------------------------------
// chained_hash_table_engine: exact-match key/value table with chained buckets
// find, insert, remove and clear over a dense slot memory and a head memory
// ---------------------------------------------------------------------------
// each request but clear is hashed first, then takes one head read and one slot read
//   per chain entry visited; remove may add a move and a second chain walk
// one request at a time: s_tready is high only in idle, so a new request waits
//   until the result of the last one is loaded into the output register
// clear and synchronous reset both empty every bucket and the count
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_table_engine #(
  parameter int CAPACITY   = chte_pkg::DEF_CAPACITY,
  parameter int BUCKETS    = chte_pkg::DEF_BUCKETS,
  parameter int KEY_BYTES  = chte_pkg::DEF_KEY_BYTES,
  parameter int VALUE_BITS = chte_pkg::DEF_VALUE_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [chte_pkg::IN_DATA_W-1:0]  s_tdata,  // key[63:0], value[95:64]
  input  wire logic [chte_pkg::KIND_W-1:0]     s_tuser,  // kind[1:0]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [chte_pkg::OUT_DATA_W-1:0]      m_tdata,  // found_value[31:0], entry_count[37:32]
  output logic [chte_pkg::STATUS_W-1:0]        m_tuser   // status[1:0]
);
  import chte_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int BW = $clog2(BUCKETS);
  localparam int KW = 8 * KEY_BYTES;
  localparam int VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [VW-1:0] value;
    logic [BW-1:0] bucket;
    logic [IW-1:0] next;
    logic          next_ok;
  } slot_t;

  // memories
  slot_t         slot_mem [CAPACITY];
  logic [IW-1:0] head_mem [BUCKETS];
  logic          used [BUCKETS];

  slot_t         sl_rd, sl_wdata;
  logic          sl_we;
  logic [IW-1:0] sl_raddr, sl_waddr;
  logic [IW-1:0] bk_rd, bk_wdata;
  logic          bk_we, used_wval, clr_all;
  logic [BW-1:0] bk_raddr, bk_waddr;

  // control registers
  state_t        state, state_next;
  kind_t         kind, kind_next;
  logic [KW-1:0] key, key_next;
  logic [VW-1:0] val, val_next;
  logic [BW-1:0] bkt, bkt_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] prev, prev_next;
  slot_t         prev_rec, prev_rec_next;
  logic          has_prev, has_prev_next;
  logic [IW-1:0] at, at_next;
  logic [CW-1:0] count, count_next;
  status_t       res_status, res_status_next;
  logic [VALUE_W-1:0] res_fv, res_fv_next;
  logic          out_load, hash_start, hash_done;
  logic [BW-1:0] hash_bucket;
  logic [IW-1:0] last;

  logic [63:0]   in_key_masked;
  assign in_key_masked = s_tdata[63:0] & ({64{1'b1}} >> (64 - KW));
  assign last = IW'(count - CW'(1));

  chte_hash #(
    .BUCKETS  (BUCKETS),
    .KEY_BYTES(KEY_BYTES),
    .BW       (BW)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (in_key_masked),
    .done  (hash_done),
    .bucket(hash_bucket)
  );

  always_ff @(posedge clk) begin
    if (sl_we) begin
      slot_mem[sl_waddr] <= sl_wdata;
    end
    sl_rd <= slot_mem[sl_raddr];
  end

  always_ff @(posedge clk) begin
    if (bk_we) begin
      head_mem[bk_waddr] <= bk_wdata;
    end
    bk_rd <= head_mem[bk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      for (int i = 0; i < BUCKETS; i++) begin
        used[i] <= 1'b0;
      end
    end else if (bk_we) begin
      used[bk_waddr] <= used_wval;
    end
  end

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    key_next        = key;
    val_next        = val;
    bkt_next        = bkt;
    cur_next        = cur;
    prev_next       = prev;
    prev_rec_next   = prev_rec;
    has_prev_next   = has_prev;
    at_next         = at;
    count_next      = count;
    res_status_next = res_status;
    res_fv_next     = res_fv;
    sl_we     = 1'b0;
    sl_waddr  = cur;
    sl_wdata  = sl_rd;
    sl_raddr  = cur;
    bk_we     = 1'b0;
    bk_waddr  = bkt;
    bk_wdata  = '0;
    used_wval = 1'b0;
    bk_raddr  = bkt;
    clr_all   = 1'b0;
    hash_start = 1'b0;
    out_load   = 1'b0;
    s_tready   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          kind_next       = kind_t'(s_tuser);
          key_next        = in_key_masked[KW-1:0];
          val_next        = s_tdata[64 +: VW];
          res_status_next = STATUS_OK;
          res_fv_next     = '0;
          if (kind_t'(s_tuser) == KIND_CLEAR) begin
            clr_all    = 1'b1;
            count_next = '0;
            state_next = ST_RESP;
          end else begin
            hash_start = 1'b1;
            state_next = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        has_prev_next = 1'b0;
        if (hash_done) begin
          bkt_next   = hash_bucket;
          bk_raddr   = hash_bucket;
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (used[bkt]) begin
          cur_next   = bk_rd;
          sl_raddr   = bk_rd;
          state_next = ST_WALK;
        end else begin
          state_next = ST_MISS;
        end
      end
      ST_WALK: begin
        if (sl_rd.key == key) begin
          at_next = cur;
          unique case (kind)
            KIND_FIND: begin
              res_fv_next = VALUE_W'(sl_rd.value);
              state_next  = ST_RESP;
            end
            KIND_INSERT: begin
              sl_we          = 1'b1;
              sl_waddr       = cur;
              sl_wdata       = sl_rd;
              sl_wdata.value = val;
              state_next     = ST_RESP;
            end
            default: begin
              // unlink the hit entry from its chain
              if (has_prev) begin
                sl_we            = 1'b1;
                sl_waddr         = prev;
                sl_wdata         = prev_rec;
                sl_wdata.next    = sl_rd.next;
                sl_wdata.next_ok = sl_rd.next_ok;
              end else begin
                bk_we     = 1'b1;
                bk_waddr  = bkt;
                bk_wdata  = sl_rd.next;
                used_wval = sl_rd.next_ok;
              end
              if (cur != last) begin
                state_next = ST_RM_LAST;
              end else begin
                count_next = count - CW'(1);
                state_next = ST_RESP;
              end
            end
          endcase
        end else begin
          prev_next     = cur;
          prev_rec_next = sl_rd;
          has_prev_next = 1'b1;
          if (sl_rd.next_ok) begin
            cur_next = sl_rd.next;
            sl_raddr = sl_rd.next;
          end else begin
            state_next = ST_MISS;
          end
        end
      end
      ST_MISS: begin
        state_next = ST_RESP;
        if (kind != KIND_INSERT) begin
          res_status_next = STATUS_ABSENT;
        end else if (count == CW'(CAPACITY)) begin
          res_status_next = STATUS_FULL;
        end else begin
          sl_we            = 1'b1;
          sl_waddr         = IW'(count);
          sl_wdata.key     = key;
          sl_wdata.value   = val;
          sl_wdata.bucket  = bkt;
          sl_wdata.next    = '0;
          sl_wdata.next_ok = 1'b0;
          if (has_prev) begin
            state_next = ST_INS_LINK;
          end else begin
            bk_we      = 1'b1;
            bk_waddr   = bkt;
            bk_wdata   = IW'(count);
            used_wval  = 1'b1;
            count_next = count + CW'(1);
          end
        end
      end
      ST_INS_LINK: begin
        sl_we            = 1'b1;
        sl_waddr         = prev;
        sl_wdata         = prev_rec;
        sl_wdata.next    = IW'(count);
        sl_wdata.next_ok = 1'b1;
        count_next       = count + CW'(1);
        state_next       = ST_RESP;
      end
      ST_RM_LAST: begin
        sl_raddr   = last;
        state_next = ST_RM_MOVE;
      end
      ST_RM_MOVE: begin
        // last slot moves into the freed one
        sl_we      = 1'b1;
        sl_waddr   = at;
        sl_wdata   = sl_rd;
        bkt_next   = sl_rd.bucket;
        bk_raddr   = sl_rd.bucket;
        state_next = ST_RM_HEAD;
      end
      ST_RM_HEAD: begin
        if (used[bkt] && bk_rd == last) begin
          bk_we      = 1'b1;
          bk_waddr   = bkt;
          bk_wdata   = at;
          used_wval  = 1'b1;
          count_next = count - CW'(1);
          state_next = ST_RESP;
        end else if (used[bkt]) begin
          cur_next   = bk_rd;
          sl_raddr   = bk_rd;
          state_next = ST_RM_WALK;
        end else begin
          count_next = count - CW'(1);
          state_next = ST_RESP;
        end
      end
      ST_RM_WALK: begin
        if (sl_rd.next_ok && sl_rd.next == last) begin
          sl_we         = 1'b1;
          sl_waddr      = cur;
          sl_wdata      = sl_rd;
          sl_wdata.next = at;
          count_next    = count - CW'(1);
          state_next    = ST_RESP;
        end else if (sl_rd.next_ok) begin
          cur_next = sl_rd.next;
          sl_raddr = sl_rd.next;
        end else begin
          count_next = count - CW'(1);
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind       <= kind_next;
    key        <= key_next;
    val        <= val_next;
    bkt        <= bkt_next;
    cur        <= cur_next;
    prev       <= prev_next;
    prev_rec   <= prev_rec_next;
    has_prev   <= has_prev_next;
    at         <= at_next;
    res_status <= res_status_next;
    res_fv     <= res_fv_next;
    if (out_load) begin
      m_tdata <= {2'b00, ECOUNT_W'(count), res_fv};
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/chte_hash.sv =====
// ---------------------------------------------------------------------------
// chte_hash: fnv-1a 64-bit hash of a key reduced modulo the bucket count
// one key byte per cycle, then eight hash bits per cycle of the reduction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chte_hash #(
  parameter int BUCKETS   = chte_pkg::DEF_BUCKETS,
  parameter int KEY_BYTES = chte_pkg::DEF_KEY_BYTES,
  parameter int BW        = $clog2(BUCKETS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [chte_pkg::KEY_W-1:0] key,
  output logic                            done,
  output logic [BW-1:0]                   bucket
);
  import chte_pkg::*;

  hash_phase_t phase;
  logic [63:0] h;
  logic [63:0] kbuf;
  logic [2:0]  cnt;
  logic [BW-1:0] rem;
  logic [BW-1:0] rem_next;

  // restoring reduction over the top eight hash bits
  always_comb begin
    logic [BW:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < 8; i++) begin
      t = {t[BW-1:0], h[63-i]};
      if (t >= (BW+1)'(BUCKETS)) begin
        t = t - (BW+1)'(BUCKETS);
      end
    end
    rem_next = t[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_FNV;
            cnt   <= '0;
          end
        end
        PH_FNV: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'(KEY_BYTES - 1)) begin
            phase <= PH_MOD;
            cnt   <= '0;
          end
        end
        PH_MOD: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      PH_IDLE: begin
        h    <= FNV_OFFSET;
        kbuf <= key;
        rem  <= '0;
      end
      PH_FNV: begin
        h    <= fnv_step(h, kbuf[7:0]);
        kbuf <= kbuf >> 8;
      end
      PH_MOD: begin
        rem <= rem_next;
        h   <= h << 8;
      end
      default: h <= h;
    endcase
  end

  assign bucket = rem;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for chained_hash_table_engine
// keeps its own chained table, predicts status, value and count per request,
// and drives random stream traffic with gaps and stalls on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import chte_pkg::*;

class table_scoreboard;
  logic [63:0] keys[32];
  logic [31:0] vals[32];
  logic [6:0]  bkt[32];
  logic [5:0]  nxt[32];
  bit          nxt_ok[32];
  logic [5:0]  head[97];
  bit          head_ok[97];
  int          count;
  logic [39:0] pending_data[$];
  status_t     pending_status[$];
  int          errors;

  function new();
    for (int i = 0; i < 97; i++) head_ok[i] = 0;
    count = 0;
    errors = 0;
  endfunction

  function logic [6:0] bucket_of(logic [63:0] k);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    for (int i = 0; i < 8; i++) begin
      h = h ^ {56'd0, k[8*i +: 8]};
      h = h * 64'd1099511628211;
    end
    return 7'(h % 64'd97);
  endfunction

  // chain walk: hit flag, hit slot, predecessor
  function bit walk(int b, logic [63:0] k, output int at, output int prv,
                    output bit has_prv);
    int cur;
    bit ok;
    cur = int'(head[b]);
    ok = head_ok[b];
    at = 0;
    prv = 0;
    has_prv = 0;
    for (int s = 0; ok && s < 32; s++) begin
      if (keys[cur] == k) begin
        at = cur;
        return 1;
      end
      prv = cur;
      has_prv = 1;
      ok = nxt_ok[cur];
      cur = int'(nxt[cur]);
    end
    return 0;
  endfunction

  function void note_request(kind_t kind, logic [63:0] k, logic [31:0] v);
    int b, at, prv, last, lb, cur;
    bit has_prv, hit, ok;
    status_t st;
    logic [31:0] fv;
    st = STATUS_OK;
    fv = '0;
    b = int'(bucket_of(k));
    hit = walk(b, k, at, prv, has_prv);
    case (kind)
      KIND_CLEAR: begin
        for (int i = 0; i < 97; i++) head_ok[i] = 0;
        count = 0;
      end
      KIND_FIND: begin
        if (hit) fv = vals[at];
        else st = STATUS_ABSENT;
      end
      KIND_INSERT: begin
        if (hit) vals[at] = v;
        else if (count >= 32) st = STATUS_FULL;
        else begin
          keys[count] = k;
          vals[count] = v;
          bkt[count] = 7'(b);
          nxt[count] = '0;
          nxt_ok[count] = 0;
          if (has_prv) begin
            nxt[prv] = 6'(count);
            nxt_ok[prv] = 1;
          end else begin
            head[b] = 6'(count);
            head_ok[b] = 1;
          end
          count++;
        end
      end
      default: begin
        if (!hit || count == 0) st = STATUS_ABSENT;
        else begin
          last = count - 1;
          if (has_prv) begin
            nxt[prv] = nxt[at];
            nxt_ok[prv] = nxt_ok[at];
          end else begin
            head[b] = nxt[at];
            head_ok[b] = nxt_ok[at];
          end
          if (at != last) begin
            // last slot moves into the hole, repoint whoever linked to it
            lb = int'(bkt[last]);
            keys[at] = keys[last];
            vals[at] = vals[last];
            bkt[at] = 7'(lb);
            nxt[at] = nxt[last];
            nxt_ok[at] = nxt_ok[last];
            if (head_ok[lb] && head[lb] == last) head[lb] = 6'(at);
            else begin
              cur = int'(head[lb]);
              ok = head_ok[lb];
              for (int s = 0; ok && s < 32; s++) begin
                if (nxt_ok[cur] && nxt[cur] == last) begin
                  nxt[cur] = 6'(at);
                  break;
                end
                ok = nxt_ok[cur];
                cur = int'(nxt[cur]);
              end
            end
          end
          count = last;
        end
      end
    endcase
    pending_status.push_back(st);
    pending_data.push_back({6'(count), fv});
  endfunction

  function void check_result(logic [39:0] data, logic [1:0] st);
    logic [39:0] e;
    status_t es;
    if (pending_data.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    e = pending_data.pop_front();
    es = pending_status.pop_front();
    if (st !== es) begin
      $error("status expected %0d actual %0d", es, st);
      errors++;
    end
    if (data[31:0] !== e[31:0]) begin
      $error("found_value expected %h actual %h", e[31:0], data[31:0]);
      errors++;
    end
    if (data[37:32] !== e[37:32]) begin
      $error("entry_count expected %0d actual %0d", e[37:32], data[37:32]);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  table_scoreboard sb;
  logic [63:0] key_set[16];
  int cycles = 0;
  bit stim_done = 0;

  chained_hash_table_engine uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  task automatic send_request(kind_t kind, logic [63:0] k, logic [31:0] v);
    s_tvalid <= 1;
    s_tdata <= {v, k};
    s_tuser <= kind;
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, k, v);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      s_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return 64'hffff_ffff_ffff_ffff;
      2: return 64'd0;
      default: return key_set[$urandom_range(0, 15)];
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("chained_hash_table_engine verification failed");
      $finish;
    end
  end

  // result side: random stall, long stretches of always-ready
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (cycles % 3000 < 500) m_tready <= 1;
      else m_tready <= ($urandom_range(0, 9) == 0) ? 0 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    kind_t k;
    sb = new();
    for (int i = 0; i < 16; i++) key_set[i] = {$urandom, $urandom};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty misses, extremes, update, fill past full, removes, clear
    send_request(KIND_FIND, 64'd0, 32'hffff_ffff);
    send_request(KIND_REMOVE, 64'hffff_ffff_ffff_ffff, 32'd0);
    send_request(KIND_INSERT, 64'd0, 32'hffff_ffff);
    send_request(KIND_INSERT, 64'hffff_ffff_ffff_ffff, 32'd0);
    send_request(KIND_FIND, 64'd0, 32'd0);
    send_request(KIND_INSERT, 64'd0, 32'h5a5a_a5a5);
    send_request(KIND_FIND, 64'd0, 32'd0);
    send_request(KIND_FIND, 64'hffff_ffff_ffff_ffff, 32'd0);
    send_request(KIND_REMOVE, 64'd0, 32'd0);
    send_request(KIND_FIND, 64'hffff_ffff_ffff_ffff, 32'd0);
    for (int i = 0; i < 33; i++) send_request(KIND_INSERT, 64'(i * 97 + 1), $urandom);
    send_request(KIND_INSERT, 64'd1, 32'h1234_5678);
    send_request(KIND_REMOVE, 64'd98, 32'd0);
    send_request(KIND_CLEAR, 64'd0, 32'd0);
    send_request(KIND_FIND, 64'd1, 32'd0);

    for (int n = 0; n < 2000; n++) begin
      case ($urandom_range(0, 19))
        0: k = KIND_CLEAR;
        1, 2, 3, 4, 5, 6, 7: k = KIND_INSERT;
        8, 9, 10, 11: k = KIND_REMOVE;
        default: k = KIND_FIND;
      endcase
      if ($urandom_range(0, 1)) idle_gap(gap_len());
      send_request(k, pick_key(), $urandom);
      if (n == 1000) begin
        s_tvalid <= 0;
        while (sb.pending_data.size() != 0) @(posedge clk);
        for (int i = 0; i < 16; i++) key_set[i] = {$urandom, $urandom};
      end
    end
    s_tvalid <= 0;
    while (sb.pending_data.size() != 0) @(posedge clk);
    idle_gap(50);
    if (sb.errors == 0) $display("chained_hash_table_engine verification clean");
    else $display("chained_hash_table_engine verification failed");
    $finish;
  end
endmodule
